>>> sv/xxhash32_stream_hasher_defines.svh
// Assertion helpers for the xxHash32 hasher.
`ifndef XXHASH32_STREAM_HASHER_DEFINES_SVH
`define XXHASH32_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define XXH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define XXH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/xxh32_pkg.sv
`timescale 1ns / 1ps

package xxh32_pkg;

  localparam logic [31:0] PRIME1 = 32'h9E3779B1;
  localparam logic [31:0] PRIME2 = 32'h85EBCA77;
  localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
  localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
  localparam logic [31:0] PRIME5 = 32'h165667B1;

  localparam logic [2:0] FULL_WORD = 3'd4;
  localparam logic [1:0] LAST_LANE = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RND_A,
    S_RND_B,
    S_MERGE,
    S_LEN,
    S_WRD_A,
    S_WRD_B,
    S_BYT_A,
    S_BYT_B,
    S_MIX1,
    S_MIX2,
    S_OUT
  } state_e;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

endpackage

>>> sv/xxhash32_stream_hasher.sv
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// cfg       cfg_valid_i / cfg_ready_o  seed_i
// in        in_valid_i  / in_ready_o   data_word_i, byte_count_i, last_i
// out       out_valid_o / out_ready_i  hash_o
//
// A word that closes no stripe is just taken in idle; one that closes one adds
// two passes of the shared 32x32 multiplier per lane (RND_A, RND_B).
// Message end: MERGE and LEN, a multiply pair per leftover word and byte, the
// avalanche (MIX1, MIX2); S_OUT loads the output register (waits while full).
// rst_ni clears control state and the seed; no clearing pass is needed.
// in_ready_o is low from a stripe-closing or last beat until back in idle.
`include "xxhash32_stream_hasher_defines.svh"

module xxhash32_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] seed_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] hash_o
);

  xxh32_pkg::state_e state_q, state_d;

  logic [31:0] seed_q;
  logic        in_msg_q, in_msg_d;
  logic        had_q, had_d;
  logic [1:0]  wpos_q, wpos_d;
  logic [31:0] total_q, total_d;
  logic [1:0]  idx_q, idx_d;
  logic [1:0]  tail_q, tail_d;
  logic        last_q, last_d;
  logic [31:0] w_q, w_d;
  logic [31:0] prod_q, prod_d;
  logic [31:0] h_q, h_d;
  logic [31:0] lane_q [4];
  logic [31:0] lane_d [4];
  logic [31:0] buf_q [3];
  logic [31:0] buf_d [3];
  logic        out_valid_q, out_valid_d;
  logic [31:0] hash_q, hash_d;

  logic [2:0]  bc_sat;
  logic        take, go_round, last_eff, out_free;
  logic [1:0]  wpos_cur;
  logic [31:0] total_cur;
  logic        had_cur;
  logic        word_done, byte_done;
  logic [31:0] mul_op, mul_k, mul_res;
  logic [7:0]  tail_byte;
  logic [31:0] lane_word;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign hash_o      = hash_q;

  assign bc_sat    = (byte_count_i > xxh32_pkg::FULL_WORD) ? xxh32_pkg::FULL_WORD
                                                           : byte_count_i;
  assign take      = in_valid_i && in_ready_o && !((bc_sat == 3'd0) && !last_i);
  assign wpos_cur  = in_msg_q ? wpos_q : 2'd0;
  assign total_cur = in_msg_q ? total_q : 32'd0;
  assign had_cur   = in_msg_q && had_q;
  assign go_round  = (bc_sat == xxh32_pkg::FULL_WORD) && (wpos_cur == 2'd3);
  assign last_eff  = last_i || ((bc_sat != 3'd0) && (bc_sat != xxh32_pkg::FULL_WORD));
  assign word_done = (idx_q == wpos_q - 2'd1);
  assign byte_done = (idx_q == tail_q - 2'd1);
  assign out_free  = !out_valid_q || out_ready_i;

  // Shared multiplier: low 32 bits of the product.
  assign mul_res = mul_op * mul_k;

  always_comb begin
    case (idx_q)
      2'd0:    tail_byte = w_q[7:0];
      2'd1:    tail_byte = w_q[15:8];
      2'd2:    tail_byte = w_q[23:16];
      default: tail_byte = w_q[31:24];
    endcase
  end

  always_comb begin
    case (idx_q)
      2'd0:    lane_word = buf_q[0];
      2'd1:    lane_word = buf_q[1];
      2'd2:    lane_word = buf_q[2];
      default: lane_word = w_q;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      xxh32_pkg::S_IDLE: begin
        if (take) begin
          if (go_round)      state_d = xxh32_pkg::S_RND_A;
          else if (last_eff) state_d = xxh32_pkg::S_MERGE;
        end
      end
      xxh32_pkg::S_RND_A: state_d = xxh32_pkg::S_RND_B;
      xxh32_pkg::S_RND_B: begin
        if (idx_q != xxh32_pkg::LAST_LANE) state_d = xxh32_pkg::S_RND_A;
        else if (last_q)                   state_d = xxh32_pkg::S_MERGE;
        else                               state_d = xxh32_pkg::S_IDLE;
      end
      xxh32_pkg::S_MERGE: state_d = xxh32_pkg::S_LEN;
      xxh32_pkg::S_LEN: begin
        if (wpos_q != 2'd0)      state_d = xxh32_pkg::S_WRD_A;
        else if (tail_q != 2'd0) state_d = xxh32_pkg::S_BYT_A;
        else                     state_d = xxh32_pkg::S_MIX1;
      end
      xxh32_pkg::S_WRD_A: state_d = xxh32_pkg::S_WRD_B;
      xxh32_pkg::S_WRD_B: begin
        if (!word_done)          state_d = xxh32_pkg::S_WRD_A;
        else if (tail_q != 2'd0) state_d = xxh32_pkg::S_BYT_A;
        else                     state_d = xxh32_pkg::S_MIX1;
      end
      xxh32_pkg::S_BYT_A: state_d = xxh32_pkg::S_BYT_B;
      xxh32_pkg::S_BYT_B: state_d = byte_done ? xxh32_pkg::S_MIX1 : xxh32_pkg::S_BYT_A;
      xxh32_pkg::S_MIX1:  state_d = xxh32_pkg::S_MIX2;
      xxh32_pkg::S_MIX2:  state_d = xxh32_pkg::S_OUT;
      xxh32_pkg::S_OUT:   if (out_free) state_d = xxh32_pkg::S_IDLE;
      default:            state_d = xxh32_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: ready and multiplier operand selection
  always_comb begin
    in_ready_o = 1'b0;
    mul_op     = 32'd0;
    mul_k      = xxh32_pkg::PRIME1;
    unique case (state_q)
      xxh32_pkg::S_IDLE:  in_ready_o = 1'b1;
      xxh32_pkg::S_RND_A: begin
        mul_op = lane_word;
        mul_k  = xxh32_pkg::PRIME2;
      end
      xxh32_pkg::S_RND_B: begin
        mul_op = xxh32_pkg::rotl(lane_q[idx_q] + prod_q, 13);
        mul_k  = xxh32_pkg::PRIME1;
      end
      xxh32_pkg::S_WRD_A: begin
        mul_op = lane_word;
        mul_k  = xxh32_pkg::PRIME3;
      end
      xxh32_pkg::S_WRD_B: begin
        mul_op = xxh32_pkg::rotl(h_q + prod_q, 17);
        mul_k  = xxh32_pkg::PRIME4;
      end
      xxh32_pkg::S_BYT_A: begin
        mul_op = {24'd0, tail_byte};
        mul_k  = xxh32_pkg::PRIME5;
      end
      xxh32_pkg::S_BYT_B: begin
        mul_op = xxh32_pkg::rotl(h_q + prod_q, 11);
        mul_k  = xxh32_pkg::PRIME1;
      end
      xxh32_pkg::S_MIX1: begin
        mul_op = h_q ^ (h_q >> 15);
        mul_k  = xxh32_pkg::PRIME2;
      end
      xxh32_pkg::S_MIX2: begin
        mul_op = h_q ^ (h_q >> 13);
        mul_k  = xxh32_pkg::PRIME3;
      end
      default: begin
        mul_op = 32'd0;
        mul_k  = xxh32_pkg::PRIME1;
      end
    endcase
  end

  // Datapath updates
  always_comb begin
    in_msg_d    = in_msg_q;
    had_d       = had_q;
    wpos_d      = wpos_q;
    total_d     = total_q;
    idx_d       = idx_q;
    tail_d      = tail_q;
    last_d      = last_q;
    w_d         = w_q;
    prod_d      = prod_q;
    h_d         = h_q;
    hash_d      = hash_q;
    out_valid_d = out_valid_q && !out_ready_i;
    for (int i = 0; i < 4; i++) lane_d[i] = lane_q[i];
    for (int i = 0; i < 3; i++) buf_d[i] = buf_q[i];

    case (state_q)
      xxh32_pkg::S_IDLE: begin
        if (take) begin
          if (!in_msg_q) begin
            lane_d[0] = seed_q + xxh32_pkg::PRIME1 + xxh32_pkg::PRIME2;
            lane_d[1] = seed_q + xxh32_pkg::PRIME2;
            lane_d[2] = seed_q;
            lane_d[3] = seed_q - xxh32_pkg::PRIME1;
          end
          in_msg_d = 1'b1;
          had_d    = had_cur;
          wpos_d   = wpos_cur;
          total_d  = total_cur + {29'd0, bc_sat};
          w_d      = data_word_i;
          last_d   = last_eff;
          tail_d   = (bc_sat == xxh32_pkg::FULL_WORD) ? 2'd0 : bc_sat[1:0];
          idx_d    = 2'd0;
          if ((bc_sat == xxh32_pkg::FULL_WORD) && !go_round) begin
            case (wpos_cur)
              2'd0:    buf_d[0] = data_word_i;
              2'd1:    buf_d[1] = data_word_i;
              default: buf_d[2] = data_word_i;
            endcase
            wpos_d = wpos_cur + 2'd1;
          end
        end
      end
      xxh32_pkg::S_RND_A: prod_d = mul_res;
      xxh32_pkg::S_RND_B: begin
        lane_d[idx_q] = mul_res;
        idx_d         = idx_q + 2'd1;
        if (idx_q == xxh32_pkg::LAST_LANE) begin
          had_d  = 1'b1;
          wpos_d = 2'd0;
        end
      end
      xxh32_pkg::S_MERGE: begin
        if (had_q) begin
          h_d = xxh32_pkg::rotl(lane_q[0], 1) + xxh32_pkg::rotl(lane_q[1], 7)
              + xxh32_pkg::rotl(lane_q[2], 12) + xxh32_pkg::rotl(lane_q[3], 18);
        end else begin
          h_d = lane_q[2] + xxh32_pkg::PRIME5;
        end
      end
      xxh32_pkg::S_LEN: begin
        h_d   = h_q + total_q;
        idx_d = 2'd0;
      end
      xxh32_pkg::S_WRD_A, xxh32_pkg::S_BYT_A: prod_d = mul_res;
      xxh32_pkg::S_WRD_B: begin
        h_d   = mul_res;
        idx_d = word_done ? 2'd0 : idx_q + 2'd1;
      end
      xxh32_pkg::S_BYT_B: begin
        h_d   = mul_res;
        idx_d = idx_q + 2'd1;
      end
      xxh32_pkg::S_MIX1, xxh32_pkg::S_MIX2: h_d = mul_res;
      xxh32_pkg::S_OUT: begin
        if (out_free) begin
          hash_d      = h_q ^ (h_q >> 16);
          out_valid_d = 1'b1;
          in_msg_d    = 1'b0;
          had_d       = 1'b0;
          wpos_d      = 2'd0;
          total_d     = 32'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xxh32_pkg::S_IDLE;
      seed_q      <= 32'd0;
      in_msg_q    <= 1'b0;
      had_q       <= 1'b0;
      wpos_q      <= 2'd0;
      total_q     <= 32'd0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i && cfg_ready_o) seed_q <= seed_i;
      in_msg_q    <= in_msg_d;
      had_q       <= had_d;
      wpos_q      <= wpos_d;
      total_q     <= total_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_q <= tail_d;
    last_q <= last_d;
    w_q    <= w_d;
    prod_q <= prod_d;
    h_q    <= h_d;
    hash_q <= hash_d;
    for (int i = 0; i < 4; i++) lane_q[i] <= lane_d[i];
    for (int i = 0; i < 3; i++) buf_q[i] <= buf_d[i];
  end

  `XXH_ASSERT_NOW(a_idle_msg_clear, !in_msg_q, (wpos_q == 2'd0) && (total_q == 32'd0) && !had_q, "closed message left stripe state behind")
  `XXH_ASSERT_NEXT(a_round_start, (state_q == xxh32_pkg::S_IDLE) && take && go_round, (state_q == xxh32_pkg::S_RND_A) && (idx_q == 2'd0), "stripe close did not start lane rounds")
  `XXH_ASSERT_NEXT(a_round_end, (state_q == xxh32_pkg::S_RND_B) && (idx_q == xxh32_pkg::LAST_LANE), had_q && (wpos_q == 2'd0), "stripe state not updated after last lane")
  `XXH_ASSERT_NEXT(a_result_out, (state_q == xxh32_pkg::S_OUT) && out_free, out_valid_o && !in_msg_q && (state_q == xxh32_pkg::S_IDLE), "finished hash not presented")

endmodule
